// ----- src/binary_morphology_3x3_top_assert.svh -----
// Assertion macros for the RTL file that checks its own logic.
`ifndef BINARY_MORPHOLOGY_3X3_TOP_ASSERT_SVH
`define BINARY_MORPHOLOGY_3X3_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BM3_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("morphology check failed");

// Check that cons holds in the cycle after ante.
`define BM3_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("morphology sequencing check failed");

`endif

// ----- src/bm3_pkg.sv -----
package bm3_pkg;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int COLS_W   = 12;
  localparam int ROW_W    = 13;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  // Geometry limits
  localparam int MAX_COLS_DEF = 2048;
  localparam int COLS_MIN     = 3;
  localparam int ROWS_MIN     = 3;
  localparam int ROWS_MAX     = 4096;

  // Pixel levels
  localparam logic [PIX_W-1:0] FG_LEVEL = 8'd255;
  localparam logic [PIX_W-1:0] BG_LEVEL = 8'd0;

  // Register reset values
  localparam logic              RST_BINARIZE  = 1'b1;
  localparam logic [PIX_W-1:0]  RST_THRESHOLD = 8'd100;
  localparam logic              RST_MODE      = 1'b0;
  localparam logic [COLS_W-1:0] RST_COLS      = 12'd640;
  localparam logic [ROW_W-1:0]  RST_ROWS      = 13'd480;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_BINARIZE_ENABLE = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_LEVEL = 3'd1;
  localparam logic [2:0] REG_MORPH_MODE      = 3'd2;
  localparam logic [2:0] REG_FRAME_COLS      = 3'd3;
  localparam logic [2:0] REG_FRAME_ROWS      = 3'd4;

  // Morphology operations
  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  typedef struct packed {
    logic              binarize_enable;
    logic [PIX_W-1:0]  threshold_level;
    logic              morph_mode;
    logic [COLS_W-1:0] frame_cols;
    logic [ROW_W-1:0]  frame_rows;
  } cfg_t;

  // Per-item control handed from the scan stage to the window stage
  typedef struct packed {
    logic fg;          // foreground bit of the incoming pixel
    logic top_ok;      // row two lines up lies in the frame
    logic mid_ok;      // row one line up lies in the frame
    logic known;       // line entry was written since reset
    logic first_col;   // column zero of a line
    logic emit;        // item produces a result
    logic last_frame;  // result closes the frame
    logic frame_end;   // position and window return to zero
  } item_t;

endpackage

// ----- src/bm3_pix_if.sv -----
interface bm3_pix_if;
  import bm3_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink (input valid, input pixel, input flush, output ready);
endinterface

// ----- src/bm3_res_if.sv -----
interface bm3_res_if;
  import bm3_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             end_of_line;
  logic             end_of_frame;

  modport source (output valid, output out_pixel, output end_of_line, output end_of_frame,
                  input ready);
  modport sink (input valid, input out_pixel, input end_of_line, input end_of_frame,
                output ready);
endinterface

// ----- src/bm3_cfg.sv -----
module bm3_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bm3_pkg::APB_AW-1:0] paddr,
  input  logic [bm3_pkg::APB_DW-1:0] pwdata,
  output logic [bm3_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output bm3_pkg::cfg_t               cfg
);
  import bm3_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_stb;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_stb  = psel && penable && pwrite;

  // Update the addressed register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.binarize_enable <= RST_BINARIZE;
      cfg.threshold_level <= RST_THRESHOLD;
      cfg.morph_mode      <= RST_MODE;
      cfg.frame_cols      <= RST_COLS;
      cfg.frame_rows      <= RST_ROWS;
    end else if (wr_stb) begin
      case (reg_idx)
        REG_BINARIZE_ENABLE: cfg.binarize_enable <= pwdata[0];
        REG_THRESHOLD_LEVEL: cfg.threshold_level <= pwdata[PIX_W-1:0];
        REG_MORPH_MODE:      cfg.morph_mode      <= pwdata[0];
        REG_FRAME_COLS:      cfg.frame_cols      <= pwdata[COLS_W-1:0];
        REG_FRAME_ROWS:      cfg.frame_rows      <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      REG_BINARIZE_ENABLE: prdata = APB_DW'(cfg.binarize_enable);
      REG_THRESHOLD_LEVEL: prdata = APB_DW'(cfg.threshold_level);
      REG_MORPH_MODE:      prdata = APB_DW'(cfg.morph_mode);
      REG_FRAME_COLS:      prdata = APB_DW'(cfg.frame_cols);
      REG_FRAME_ROWS:      prdata = APB_DW'(cfg.frame_rows);
      default:             prdata = '0;
    endcase
  end
endmodule

// ----- src/bm3_linebuf.sv -----
module bm3_linebuf #(
  parameter int MAX_COLS = bm3_pkg::MAX_COLS_DEF,
  parameter int ADDR_W   = $clog2(MAX_COLS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [1:0]        wr_data,
  output logic [1:0]        rd_data
);
  import bm3_pkg::*;

  // Each entry: bit 1 = line two up, bit 0 = line one up
  logic [1:0] mem [0:MAX_COLS-1];
  logic [1:0] mem_q;
  logic [1:0] fwd_q;
  logic       hit_q;

  // Write back and read; capture a colliding write for forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      hit_q <= wr_en && (wr_addr == rd_addr);
      fwd_q <= wr_data;
    end
  end

  assign rd_data = hit_q ? fwd_q : mem_q;
endmodule

// ----- src/bm3_scan.sv -----
module bm3_scan #(
  parameter int MAX_COLS = bm3_pkg::MAX_COLS_DEF,
  parameter int ADDR_W   = $clog2(MAX_COLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  bm3_pkg::cfg_t      cfg,
  bm3_pix_if.sink            pix_in,
  input  logic               take,
  output logic               issue_valid,
  output bm3_pkg::item_t     issue,
  output logic [ADDR_W-1:0]  rd_addr,
  output logic [ADDR_W:0]    fill,
  output logic               at_origin
);
  import bm3_pkg::*;

  localparam int CW = (ADDR_W + 1 > COLS_W) ? ADDR_W + 1 : COLS_W;

  logic [ADDR_W-1:0] col;
  logic [ROW_W-1:0]  row;
  logic [CW-1:0]     cols_raw;
  logic [CW-1:0]     cols_eff;
  logic [CW-1:0]     col_inc;
  logic [ROW_W-1:0]  rows_eff;
  logic [ROW_W-1:0]  rows_p1;
  logic [ROW_W-1:0]  rows_p2;
  logic              accept;
  logic              first_col;
  logic              in_frame;

  assign pix_in.ready = take;
  assign accept       = pix_in.valid && take;
  assign at_origin    = (row == '0) && (col == '0);
  assign first_col    = (col == '0);
  assign issue_valid  = accept && !(pix_in.flush && at_origin);
  assign rd_addr      = col;

  // Clamp the geometry
  always_comb begin
    cols_raw = CW'(cfg.frame_cols);
    if (cols_raw < CW'(COLS_MIN)) begin
      cols_eff = CW'(COLS_MIN);
    end else if (cols_raw > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
    if (cfg.frame_rows < ROW_W'(ROWS_MIN)) begin
      rows_eff = ROW_W'(ROWS_MIN);
    end else if (cfg.frame_rows > ROW_W'(ROWS_MAX)) begin
      rows_eff = ROW_W'(ROWS_MAX);
    end else begin
      rows_eff = cfg.frame_rows;
    end
  end

  assign col_inc  = CW'(col) + CW'(1);
  assign rows_p1  = rows_eff + ROW_W'(1);
  assign rows_p2  = rows_eff + ROW_W'(2);
  assign in_frame = !pix_in.flush && (row < rows_eff);

  // Classify the item at the current position
  always_comb begin
    if (!in_frame) begin
      issue.fg = 1'b0;
    end else if (cfg.binarize_enable) begin
      issue.fg = (pix_in.pixel <= cfg.threshold_level);
    end else begin
      issue.fg = (pix_in.pixel == FG_LEVEL);
    end
    issue.top_ok     = (row >= ROW_W'(2));
    issue.mid_ok     = (row >= ROW_W'(1));
    issue.known      = ({1'b0, col} < fill);
    issue.first_col  = first_col;
    issue.emit       = first_col ? ((row >= ROW_W'(2)) && (row < rows_p2))
                                 : ((row >= ROW_W'(1)) && (row < rows_p1));
    issue.last_frame = first_col && (row == rows_p1);
    issue.frame_end  = first_col && (row >= rows_p1);
  end

  // Advance the raster position and the written-entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      fill <= '0;
    end else if (issue_valid) begin
      if (!issue.known) begin
        fill <= {1'b0, col} + (ADDR_W+1)'(1);
      end
      if (issue.frame_end) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= cols_eff) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col_inc[ADDR_W-1:0];
      end
    end
  end
endmodule

// ----- src/bm3_window.sv -----
module bm3_window #(
  parameter int MAX_COLS = bm3_pkg::MAX_COLS_DEF,
  parameter int ADDR_W   = $clog2(MAX_COLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               morph_mode,
  input  logic               issue_valid,
  input  bm3_pkg::item_t     issue,
  input  logic [ADDR_W-1:0]  issue_addr,
  input  logic [1:0]         rd_data,
  output logic               take,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [1:0]         wr_data,
  bm3_res_if.source          res_out
);
  import bm3_pkg::*;

  logic              s1_valid;
  item_t             s1;
  logic [ADDR_W-1:0] s1_addr;
  logic [2:0]        win_mid;
  logic [2:0]        win_new;
  logic [1:0]        entry;
  logic              top;
  logic              mid;
  logic [2:0]        newcol;
  logic [2:0]        right;
  logic              res;
  logic              out_free;
  logic              s1_adv;

  // Rebuild the column under the incoming pixel
  assign entry  = s1.known ? rd_data : 2'b00;
  assign top    = s1.top_ok && entry[1];
  assign mid    = s1.mid_ok && entry[0];
  assign newcol = {s1.fg, mid, top};
  assign right  = s1.first_col ? 3'b000 : newcol;

  // Apply the structuring element
  always_comb begin
    if (morph_mode == MODE_DILATE) begin
      res = |(win_mid | win_new | right);
    end else begin
      res = (win_new == 3'b111) && win_mid[1] && right[1];
    end
  end

  assign out_free = !res_out.valid || res_out.ready;
  assign s1_adv   = s1_valid && (!s1.emit || out_free);
  assign take     = !s1_valid || s1_adv;

  // Write the shifted column back to the line memory
  assign wr_en   = s1_adv;
  assign wr_addr = s1_addr;
  assign wr_data = {mid, s1.fg};

  // Hold or load the memory-read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && issue_valid) begin
      s1      <= issue;
      s1_addr <= issue_addr;
    end
  end

  // Shift the window
  always_ff @(posedge clk) begin
    if (rst) begin
      win_mid <= '0;
      win_new <= '0;
    end else if (s1_adv) begin
      if (s1.frame_end) begin
        win_mid <= '0;
        win_new <= '0;
      end else begin
        win_mid <= s1.first_col ? 3'b000 : win_new;
        win_new <= newcol;
      end
    end
  end

  // Output register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      res_out.out_pixel    <= res ? FG_LEVEL : BG_LEVEL;
      res_out.end_of_line  <= s1.first_col;
      res_out.end_of_frame <= s1.last_frame;
    end
  end
endmodule

// ----- src/binary_morphology_3x3_top.sv -----
// 3x3 binary erosion / dilation over a raster pixel stream.
// pix_in carries one gray pixel per transaction in raster order, plus a
// flush bit; after each frame send frame_cols+1 flush transactions to drain
// it. res_out carries one result pixel (255 or 0) with end-of-line and
// end-of-frame marks. A result belongs to the pixel one line and one pixel
// before the input that completes its neighborhood; it passes through the
// memory-read stage into the output register, which holds it until taken.
// Sustained rate is one pixel per clock while res_out does not stall: each
// pixel does one read-modify-write of a single line memory (two bits per
// column, registered read), with a write-to-read bypass for back-to-back
// accesses to the same column.
// Configuration goes through the APB port; the user must write it only
// between frames or while the stream is idle, which the block does not
// enforce. Reset restores register defaults and zeroes the raster position
// and window; the line memory is not swept, a count of written columns
// makes untouched entries read as background. When res_out stalls the
// output register holds its result, a pixel with a result waits in the read
// stage, and pix_in.ready stays low until the output drains.
module binary_morphology_3x3_top #(
  parameter int MAX_COLS = bm3_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  bm3_pix_if.sink                     pix_in,
  bm3_res_if.source                   res_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bm3_pkg::APB_AW-1:0] paddr,
  input  logic [bm3_pkg::APB_DW-1:0] pwdata,
  output logic [bm3_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bm3_pkg::*;

  `include "binary_morphology_3x3_top_assert.svh"

  localparam int ADDR_W = $clog2(MAX_COLS);

  cfg_t              cfg;
  item_t             issue;
  logic              issue_valid;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W:0]   fill;
  logic              at_origin;
  logic              take;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [1:0]        wr_data;
  logic [1:0]        rd_data;

  bm3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bm3_scan #(.MAX_COLS(MAX_COLS), .ADDR_W(ADDR_W)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pix_in      (pix_in),
    .take        (take),
    .issue_valid (issue_valid),
    .issue       (issue),
    .rd_addr     (rd_addr),
    .fill        (fill),
    .at_origin   (at_origin)
  );

  bm3_linebuf #(.MAX_COLS(MAX_COLS), .ADDR_W(ADDR_W)) u_linebuf (
    .clk     (clk),
    .rd_en   (issue_valid),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  bm3_window #(.MAX_COLS(MAX_COLS), .ADDR_W(ADDR_W)) u_window (
    .clk         (clk),
    .rst         (rst),
    .morph_mode  (cfg.morph_mode),
    .issue_valid (issue_valid),
    .issue       (issue),
    .issue_addr  (rd_addr),
    .rd_data     (rd_data),
    .take        (take),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_out     (res_out)
  );

  // Write-back only to columns already counted as written
  `BM3_ASSERT_SAME(a_wr_in_fill, clk, rst, wr_en, ({1'b0, wr_addr} < fill))
  // Closing drain item returns the raster position to the origin
  `BM3_ASSERT_NEXT(a_frame_wrap, clk, rst, issue_valid && issue.last_frame, at_origin)
  // Input stalls only under output backpressure
  `BM3_ASSERT_SAME(a_stall_cause, clk, rst, !pix_in.ready, res_out.valid && !res_out.ready)
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import bm3_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int RUN_CYCLES      = 1_000_000;

  // Register indexes that map to no register
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [PIX_W-1:0] level;
    logic             eol;
    logic             eof;
  } morph_result_t;

  // Predicts the morphology stream and checks the results against it
  class morph_scoreboard;
    logic              binarize;
    logic [PIX_W-1:0]  threshold;
    logic              mode;
    logic [COLS_W-1:0] cols_reg;
    logic [ROW_W-1:0]  rows_reg;
    bit                line_above [MAX_COLS_DEF];
    bit                line_middle [MAX_COLS_DEF];
    logic [8:0]        window;
    logic [COLS_W-1:0] col_pos;
    logic [ROW_W-1:0]  row_pos;
    morph_result_t     expected_pixels [$];
    int                mismatches;

    function new();
      binarize   = RST_BINARIZE;
      threshold  = RST_THRESHOLD;
      mode       = RST_MODE;
      cols_reg   = RST_COLS;
      rows_reg   = RST_ROWS;
      window     = '0;
      col_pos    = '0;
      row_pos    = '0;
      mismatches = 0;
    endfunction

    function int eff_cols();
      if (cols_reg < COLS_MIN) return COLS_MIN;
      if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
      return int'(cols_reg);
    endfunction

    function int eff_rows();
      if (rows_reg < ROWS_MIN) return ROWS_MIN;
      if (rows_reg > ROWS_MAX) return ROWS_MAX;
      return int'(rows_reg);
    endfunction

    function void write_reg(logic [2:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_BINARIZE_ENABLE: binarize = value[0];
        REG_THRESHOLD_LEVEL: threshold = value[PIX_W-1:0];
        REG_MORPH_MODE: mode = value[0];
        REG_FRAME_COLS: cols_reg = value[COLS_W-1:0];
        REG_FRAME_ROWS: rows_reg = value[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DW-1:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_BINARIZE_ENABLE: return APB_DW'(binarize);
        REG_THRESHOLD_LEVEL: return APB_DW'(threshold);
        REG_MORPH_MODE: return APB_DW'(mode);
        REG_FRAME_COLS: return APB_DW'(cols_reg);
        REG_FRAME_ROWS: return APB_DW'(rows_reg);
        default: return '0;
      endcase
    endfunction

    function bit at_frame_start();
      return (row_pos == 0) && (col_pos == 0);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Advance the raster by one accepted transaction; returns 0 if it was ignored
    function bit note_pixel(logic [PIX_W-1:0] pix, logic fl);
      int            cols, rows, r, c;
      logic          fg, top, mid, emit, hit;
      logic [2:0]    newcol, oldm, oldr, right;
      morph_result_t res;
      cols = eff_cols();
      rows = eff_rows();
      r = int'(row_pos);
      c = int'(col_pos);
      // drop a flush while no frame is in progress
      if (fl && r == 0 && c == 0) return 1'b0;

      if (fl || r >= rows) fg = 1'b0;
      else if (binarize) fg = (pix <= threshold);
      else fg = (pix == FG_LEVEL);

      top = (r >= 2) ? line_above[c] : 1'b0;
      mid = (r >= 1) ? line_middle[c] : 1'b0;
      line_above[c] = mid;
      line_middle[c] = fg;
      newcol = {fg, mid, top};

      oldm = window[5:3];
      oldr = window[8:6];
      right = (c == 0) ? 3'b000 : newcol;
      emit = (c == 0) ? (r >= 2 && r - 2 < rows) : (r >= 1 && r - 1 < rows);

      if (emit) begin
        if (mode == MODE_DILATE) hit = |{oldm, oldr, right};
        else hit = (oldr == 3'b111) && oldm[1] && right[1];
        res.level = hit ? FG_LEVEL : BG_LEVEL;
        res.eol = (c == 0);
        res.eof = (c == 0) && (r == rows + 1);
        expected_pixels.insert(expected_pixels.size(), res);
      end

      window = (c == 0) ? {newcol, 6'b000000} : {newcol, oldr, oldm};

      // close the frame, wrap the line, or step the column
      if (c == 0 && r >= rows + 1) begin
        row_pos = '0;
        col_pos = '0;
        window = '0;
      end else if (c + 1 >= cols) begin
        col_pos = '0;
        row_pos = ROW_W'(r + 1);
      end else begin
        col_pos = COLS_W'(c + 1);
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [APB_DW-1:0] exp_val,
                                logic [APB_DW-1:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] level, logic eol, logic eof);
      morph_result_t exp_res;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result: expected none actual out_pixel %0d eol %0d eof %0d",
                 $time, level, eol, eof);
        mismatches++;
        return;
      end
      exp_res = expected_pixels.pop_front();
      compare_field("out_pixel", APB_DW'(exp_res.level), APB_DW'(level));
      compare_field("end_of_line", APB_DW'(exp_res.eol), APB_DW'(eol));
      compare_field("end_of_frame", APB_DW'(exp_res.eof), APB_DW'(eof));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  bm3_pix_if pix_if ();
  bm3_res_if res_if ();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int hold_at_frame = 0;
  int random_items = 0;
  bit pause_mid_frame = 1'b0;

  // Erosion cross on the center pixel at threshold zero
  logic [PIX_W-1:0] cross_frame [9] = '{8'd200, 8'd0, 8'd128,
                                        8'd0, 8'd0, 8'd0,
                                        8'd255, 8'd0, 8'd1};

  morph_scoreboard sb = new();

  binary_morphology_3x3_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Drive the result ready: long hold-offs on request, else random stalls
  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.out_pixel, res_if.end_of_line, res_if.end_of_frame);
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, then read it back where one exists
  task automatic set_reg(logic [2:0] idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    apb_write({idx, 2'b00}, value);
    sb.write_reg(idx, value);
    if (idx <= REG_FRAME_ROWS) begin
      apb_read({idx, 2'b00}, rd);
      sb.compare_field("register readback", sb.reg_value(idx), rd);
    end
  endtask

  // Drop valid and hold until every expected result is out
  task automatic pause_until_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Let the pipeline empty before touching configuration
  task automatic settle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic [PIX_W-1:0] pix, logic fl);
    if ($urandom_range(99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= pix;
    pix_if.flush <= fl;
    do @(posedge clk); while (!pix_if.ready);
    if (sb.note_pixel(pix, fl)) random_items++;
  endtask

  // Drain until the raster position is back at zero; some drains carry pixels
  task automatic finish_frame();
    while (!sb.at_frame_start())
      send_item(PIX_W'($urandom_range(255)), $urandom_range(9) != 0);
  endtask

  // Pixel biased toward foreground or background for the current settings
  function automatic logic [PIX_W-1:0] pick_pixel(int density);
    logic [PIX_W-1:0] thr;
    thr = sb.threshold;
    if ($urandom_range(99) < 15) return PIX_W'($urandom_range(255));
    if ($urandom_range(99) < density) begin
      if (!sb.binarize) return FG_LEVEL;
      return ($urandom_range(3) == 0) ? thr : PIX_W'($urandom_range(thr, 0));
    end
    if (!sb.binarize) return PIX_W'($urandom_range(254));
    if (thr == FG_LEVEL) return PIX_W'($urandom_range(255));
    return ($urandom_range(3) == 0) ? thr + 8'd1 : PIX_W'($urandom_range(255, thr + 1));
  endfunction

  task automatic send_frame();
    int pixels;
    int density;
    int noisy_pct;
    pixels = sb.eff_cols() * sb.eff_rows();
    // cut some frames short; the drain fills the rest, mostly as background
    if ($urandom_range(19) == 0) pixels = $urandom_range(pixels - 1, 0);
    noisy_pct = ($urandom_range(9) == 0) ? 30 : 2;
    density = $urandom_range(100);
    if (hold_at_frame > 0) begin
      rx_hold_req = hold_at_frame;
      hold_at_frame = 0;
    end
    if ($urandom_range(3) == 0) send_item(PIX_W'($urandom_range(255)), 1'b1);
    for (int i = 0; i < pixels; i++) begin
      if (pause_mid_frame && i == pixels / 2) begin
        pause_until_drained();
        pause_mid_frame = 1'b0;
      end
      send_item(pick_pixel(density), $urandom_range(99) < noisy_pct);
    end
    finish_frame();
  endtask

  task automatic random_config();
    int pick;
    logic [APB_DW-1:0] thr_val;
    logic [APB_DW-1:0] cols_val;
    logic [APB_DW-1:0] rows_val;
    pick = $urandom_range(4);
    if (pick == 0) thr_val = 0;
    else if (pick == 1) thr_val = 255;
    else thr_val = $urandom_range(255);
    pick = $urandom_range(19);
    if (pick == 0) cols_val = $urandom_range(2);
    else if (pick == 1) cols_val = $urandom_range(24, 9);
    else cols_val = $urandom_range(8, 3);
    rows_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
    set_reg(REG_BINARIZE_ENABLE, $urandom_range(1));
    set_reg(REG_THRESHOLD_LEVEL, thr_val);
    set_reg(REG_MORPH_MODE, APB_DW'($urandom_range(1) ? MODE_DILATE : MODE_ERODE));
    set_reg(REG_FRAME_COLS, cols_val);
    set_reg(REG_FRAME_ROWS, rows_val);
  endtask

  task automatic run_random(int tx_pct, int rx_pct, int count);
    int start_count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_count = random_items;
    while (random_items - start_count < count) begin
      settle();
      random_config();
      repeat ($urandom_range(3, 1)) send_frame();
    end
  endtask

  initial begin
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    pix_if.flush <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tx_idle_pct = 27;
    rx_idle_pct = 88;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // 3x3 erosion frame with clamped geometry and the threshold at zero
    set_reg(REG_BINARIZE_ENABLE, 1);
    set_reg(REG_THRESHOLD_LEVEL, 0);
    set_reg(REG_MORPH_MODE, APB_DW'(MODE_ERODE));
    set_reg(REG_FRAME_COLS, 0);
    set_reg(REG_FRAME_ROWS, 2);
    set_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    set_reg(REG_SPARE_HI, 32'h0000_0001);
    send_item(8'd255, 1'b1);
    foreach (cross_frame[i]) send_item(cross_frame[i], 1'b0);
    send_item(8'd0, 1'b0);
    finish_frame();

    // dilation on raw 255 pixels, flush inside the frame, then a mid-frame change
    settle();
    set_reg(REG_BINARIZE_ENABLE, 0);
    set_reg(REG_THRESHOLD_LEVEL, 255);
    set_reg(REG_MORPH_MODE, APB_DW'(MODE_DILATE));
    set_reg(REG_FRAME_COLS, 4);
    set_reg(REG_FRAME_ROWS, 3);
    send_item(8'd254, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    settle();
    set_reg(REG_MORPH_MODE, APB_DW'(MODE_ERODE));
    set_reg(REG_FRAME_COLS, 3);
    repeat (4) send_item(8'd255, 1'b0);
    finish_frame();

    // random frames under three idling patterns
    pause_mid_frame = 1'b1;
    run_random(27, 88, ITEMS_PER_PHASE);
    run_random(88, 27, ITEMS_PER_PHASE);
    hold_at_frame = HOLD_OFF_CYCLES;
    run_random(0, 0, ITEMS_PER_PHASE);

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("binary_morphology_3x3_top test passed");
    end else begin
      $display("binary_morphology_3x3_top test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    repeat (RUN_CYCLES) @(posedge clk);
    $display("binary_morphology_3x3_top test failed");
    $finish;
  end

endmodule
